@@ rtl/cltl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cltl_pkg
// Types and constants shared by the clamped linear table interpolator.
// ----------------------------------------------------------------------------
package cltl_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int VALUE_W         = 32;
   localparam int IDX_W           = 6;
   localparam int COUNT_W         = 7;
   localparam int WEIGHT_FRAC     = 16;
   localparam int WEIGHT_W        = WEIGHT_FRAC + 1;
   localparam int DIV_W           = VALUE_W + 1;
   localparam int DIV_STAGES      = WEIGHT_FRAC + 1;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef struct packed {
      action_type                  action;
      logic [IDX_W-1:0]            entry_index;
      logic signed [VALUE_W-1:0]   entry_radius;
      logic signed [VALUE_W-1:0]   entry_twist;
      logic signed [VALUE_W-1:0]   entry_chord;
      logic signed [VALUE_W-1:0]   query_radius;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   interp_twist;
      logic signed [VALUE_W-1:0]   interp_chord;
      logic [IDX_W-1:0]            lower_index;
      logic [IDX_W-1:0]            upper_index;
      logic [WEIGHT_W-1:0]         weight;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/cltl_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cltl_div
// Pipelined restoring divider: quotient = floor(num * 2^16 / den) for
// num <= den, one quotient bit per stage, valid bits move with the data.
// ----------------------------------------------------------------------------
module cltl_div (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   in_valid,
   input  wire logic [cltl_pkg::DIV_W-1:0]             num,
   input  wire logic [cltl_pkg::DIV_W-1:0]             den,
   output logic                                        out_valid,
   output logic [cltl_pkg::WEIGHT_W-1:0]               quotient
);

   localparam int NS = cltl_pkg::DIV_STAGES;
   localparam int DW = cltl_pkg::DIV_W;
   localparam int QW = cltl_pkg::WEIGHT_W;

   logic [NS-1:0]        valid_ff;
   logic [DW-1:0]        rem_ff [NS];
   logic [DW-1:0]        den_ff [NS];
   logic [QW-1:0]        quo_ff [NS];
   logic [DW-1:0]        rem_in [NS];
   logic [DW-1:0]        den_in [NS];
   logic [QW-1:0]        quo_in [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         logic [DW:0]   trial_in;
         logic [DW:0]   diff_in;
         logic [QW-1:0] quo_prev;
         logic          fits;

         if (k == 0) begin : g_first
            assign trial_in  = {1'b0, num};
            assign den_in[k] = den;
            assign quo_prev  = '0;
         end else begin : g_next
            assign trial_in  = {rem_ff[k-1], 1'b0};
            assign den_in[k] = den_ff[k-1];
            assign quo_prev  = quo_ff[k-1];
         end

         assign diff_in   = trial_in - {1'b0, den_in[k]};
         assign fits      = (trial_in >= {1'b0, den_in[k]});
         assign rem_in[k] = fits ? diff_in[DW-1:0] : trial_in[DW-1:0];
         assign quo_in[k] = {quo_prev[QW-2:0], fits};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign quotient  = quo_ff[NS-1];

endmodule
`default_nettype wire

@@ rtl/clamped_linear_table_interp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_linear_table_interp
// Piecewise linear interpolation of twist and chord over a radius table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_data) carries write and query
//   transactions. A write stores one table entry and returns nothing; a
//   query returns one rsp transaction (rsp_valid/rsp_stall/rsp_data).
//   csr_wr_en/csr_wr_data set entry_count; write it only while idle.
// A query's result is presented after the search, table read, divide setup, divider, multiply and output stages.
// Throughput: one query per cycle while not frozen. A write is held off while
//   a query sits in the two stages ahead of the table read (search and read
//   address), so a write right behind queries waits until they move on.
// The divider (17 stages, one weight bit each) makes up most of the latency.
// Reset clears all pipeline valid bits and sets entry_count to 1; table
//   contents are not cleared and are undefined until written.
// When rsp_stall is high with a result waiting, the whole pipeline freezes
//   and req_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module clamped_linear_table_interp #(
   parameter int TABLE_DEPTH = cltl_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire cltl_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output cltl_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_wr_en,
   input  wire logic [cltl_pkg::COUNT_W-1:0]       csr_wr_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int VW = cltl_pkg::VALUE_W;
   localparam int XW = cltl_pkg::IDX_W;
   localparam int WW = cltl_pkg::WEIGHT_W;
   localparam int DW = cltl_pkg::DIV_W;
   localparam int NS = cltl_pkg::DIV_STAGES;
   localparam int FR = cltl_pkg::WEIGHT_FRAC;
   localparam int PW = WW + DW + 1;

   typedef struct packed {
      logic signed [VW-1:0] t1;
      logic signed [VW-1:0] t2;
      logic signed [VW-1:0] c1;
      logic signed [VW-1:0] c2;
      logic [XW-1:0]        i1;
      logic [XW-1:0]        i2;
      logic                 interp;
   } side_type;

   // control and tables
   logic [cltl_pkg::COUNT_W-1:0] entry_count_ff;
   logic signed [VW-1:0]         radius_ff  [TABLE_DEPTH];
   logic signed [VW-1:0]         radius_mem [TABLE_DEPTH];
   logic signed [VW-1:0]         twist_mem  [TABLE_DEPTH];
   logic signed [VW-1:0]         chord_mem  [TABLE_DEPTH];

   logic en;
   logic req_acc;
   logic wr_en;
   logic [IW-1:0] wr_addr;

   // stage 1
   logic              v1_ff;
   logic signed [VW-1:0] q1_ff;
   logic [CW-1:0]     n1_ff;
   logic [CW-1:0]     n1_in;

   // stage 2
   logic              v2_ff;
   logic signed [VW-1:0] q2_ff;
   logic [CW-1:0]     n2_ff;
   logic [CW-1:0]     pos2_ff;
   logic [CW-1:0]     pos_in;

   // stage 3
   logic              v3_ff;
   logic signed [VW-1:0] q3_ff;
   logic [IW-1:0]     a1_in;
   logic [IW-1:0]     a2_in;
   logic              interp_in;
   logic [IW-1:0]     a1_ff;
   logic [IW-1:0]     a2_ff;
   logic              interp3_ff;
   logic signed [VW-1:0] r1_ff, r2_ff, t1_ff, t2_ff, c1_ff, c2_ff;

   // stage 4
   logic              v4_ff;
   logic [DW-1:0]     num4_ff;
   logic [DW-1:0]     den4_ff;
   side_type          side4_ff;
   logic signed [DW-1:0] num_in;
   logic signed [DW-1:0] den_in;

   // divider
   logic              div_valid;
   logic [WW-1:0]     div_quo;
   side_type          side_ff [NS];

   // multiply stage
   logic              vm_ff;
   side_type          sidem_ff;
   logic [WW-1:0]     wm_ff;
   logic signed [PW-1:0] pt_ff;
   logic signed [PW-1:0] pc_ff;
   logic [WW-1:0]     w_in;

   // output
   logic              rsp_valid_ff;
   cltl_pkg::rsp_type rsp_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en ||
                      (req_valid && (req_data.action == cltl_pkg::ACT_WRITE) &&
                       (v1_ff || v2_ff));
   assign req_acc   = req_valid && !req_stall;
   assign wr_en     = req_acc && (req_data.action == cltl_pkg::ACT_WRITE) &&
                      (32'(req_data.entry_index) < TABLE_DEPTH);
   assign wr_addr   = IW'(req_data.entry_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= cltl_pkg::COUNT_W'(1);
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (entry_count_ff == '0) begin
         n1_in = CW'(1);
      end else if (32'(entry_count_ff) > TABLE_DEPTH) begin
         n1_in = CW'(TABLE_DEPTH);
      end else begin
         n1_in = CW'(entry_count_ff);
      end
   end

   // table write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         radius_ff[wr_addr]  <= req_data.entry_radius;
         radius_mem[wr_addr] <= req_data.entry_radius;
         twist_mem[wr_addr]  <= req_data.entry_twist;
         chord_mem[wr_addr]  <= req_data.entry_chord;
      end
      if (en) begin
         r1_ff <= radius_mem[a1_in];
         r2_ff <= radius_mem[a2_in];
         t1_ff <= twist_mem[a1_in];
         t2_ff <= twist_mem[a2_in];
         c1_ff <= chord_mem[a1_in];
         c2_ff <= chord_mem[a2_in];
      end
   end

   // search: first entry in use whose radius is not below the query
   always_comb begin
      pos_in = n1_ff;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if ((CW'(i) < n1_ff) && (radius_ff[i] >= q1_ff)) begin
            pos_in = CW'(i);
         end
      end
   end

   always_comb begin
      if ((n2_ff == CW'(1)) || (pos2_ff == '0)) begin
         a1_in     = '0;
         a2_in     = '0;
         interp_in = 1'b0;
      end else if (pos2_ff == n2_ff) begin
         a1_in     = IW'(n2_ff - CW'(1));
         a2_in     = IW'(n2_ff - CW'(1));
         interp_in = 1'b0;
      end else begin
         a1_in     = IW'(pos2_ff - CW'(1));
         a2_in     = IW'(pos2_ff);
         interp_in = 1'b1;
      end
   end

   assign num_in = DW'(q3_ff) - DW'(r1_ff);
   assign den_in = DW'(r2_ff) - DW'(r1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_acc && (req_data.action == cltl_pkg::ACT_QUERY);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         q1_ff      <= req_data.query_radius;
         n1_ff      <= n1_in;
         q2_ff      <= q1_ff;
         n2_ff      <= n1_ff;
         pos2_ff    <= pos_in;
         q3_ff      <= q2_ff;
         a1_ff      <= a1_in;
         a2_ff      <= a2_in;
         interp3_ff <= interp_in;
         num4_ff    <= num_in;
         den4_ff    <= den_in;
         side4_ff   <= '{t1: t1_ff, t2: t2_ff, c1: c1_ff, c2: c2_ff,
                         i1: XW'(a1_ff), i2: XW'(a2_ff),
                         interp: interp3_ff && (den_in > 0)};
      end
   end

   cltl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .num       (num4_ff),
      .den       (den4_ff),
      .out_valid (div_valid),
      .quotient  (div_quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side4_ff;
         for (int s = 1; s < NS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign w_in = side_ff[NS-1].interp ? div_quo : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vm_ff        <= div_valid;
         rsp_valid_ff <= vm_ff;
      end
      if (en) begin
         sidem_ff <= side_ff[NS-1];
         wm_ff    <= w_in;
         pt_ff    <= $signed({1'b0, w_in}) *
                     (DW'(side_ff[NS-1].t2) - DW'(side_ff[NS-1].t1));
         pc_ff    <= $signed({1'b0, w_in}) *
                     (DW'(side_ff[NS-1].c2) - DW'(side_ff[NS-1].c1));
         rsp_ff.interp_twist <= sidem_ff.t1 + pt_ff[FR+VW-1:FR];
         rsp_ff.interp_chord <= sidem_ff.c1 + pc_ff[FR+VW-1:FR];
         rsp_ff.lower_index  <= sidem_ff.i1;
         rsp_ff.upper_index  <= sidem_ff.i2;
         rsp_ff.weight       <= wm_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_write_order : assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_data.action == cltl_pkg::ACT_WRITE)) |-> !(v1_ff || v2_ff))
      else $error("write passed a query ahead of the table read");

   a_weight_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.weight <= WW'(1 << FR)))
      else $error("weight above one");

   a_weight_clamp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.weight != '0)) |->
         (rsp_ff.upper_index == rsp_ff.lower_index + XW'(1)))
      else $error("nonzero weight without adjacent bracket");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled response changed");
`endif

endmodule
`default_nettype wire
